FILE: design/double_hash_table_defines.svh
// assertion macros for the double hash table checker
// needs clk and rst_n in the scope where a macro is used
`ifndef DOUBLE_HASH_TABLE_DEFINES_SVH
`define DOUBLE_HASH_TABLE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define DHT_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define DHT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/dht_pkg.sv
// shared types and constants of the double hash table
// no dependencies
package dht_pkg;

    localparam int OP_W    = 2;
    localparam int KEY_W   = 31;
    localparam int START_W = 10;
    localparam int STEP_W  = 11;
    localparam int SIZE_W  = 11;
    localparam int SLOT_W  = 10;
    localparam int TAG_W   = 2;

    localparam logic [SIZE_W-1:0] TABLE_SIZE_RESET = 11'd1024;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_SEARCH = 2'd1;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd2;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    localparam logic [TAG_W-1:0] TAG_EMPTY   = 2'd0;
    localparam logic [TAG_W-1:0] TAG_USED    = 2'd1;
    localparam logic [TAG_W-1:0] TAG_DELETED = 2'd2;

    localparam int QUEUE_DEPTH = 2;

    // classified request as it waits between front and back
    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [KEY_W-1:0]   key;
        logic [START_W-1:0] start;
        logic [STEP_W-1:0]  inc;    // probe step already reduced modulo the size
        logic               bad;
        logic               nop;
    } cmd_t;

endpackage

FILE: design/double_hash_table.sv
// flow: accept into the queue, then the engine pops the head and issues the first read, then probes
// the probe engine finishes each item (1 to active size probes) before it pops the next one
// a bad or unknown request is answered without probing; each probe is one tag/key ram read
// reset: config back to 1024 slots, then a sweep over all CAPACITY slots clears every tag
// to empty, req_stall stays high during the sweep
module double_hash_table #(
    parameter int CAPACITY = 1024
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration: table size
    input  logic                          cfg_wr_en,
    input  logic [dht_pkg::SIZE_W-1:0]    cfg_wr_data,
    // request channel
    input  logic                          req_valid,
    output logic                          req_stall,
    input  logic [dht_pkg::OP_W-1:0]      req_type,
    input  logic [dht_pkg::KEY_W-1:0]     key,
    input  logic [dht_pkg::START_W-1:0]   probe_start,
    input  logic [dht_pkg::STEP_W-1:0]    probe_step,
    // result channel
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output logic                          success,
    output logic [dht_pkg::SLOT_W-1:0]    slot,
    output logic                          bad_request
);
    import dht_pkg::*;

    // active size never exceeds CAPACITY, so this width holds it
    localparam int M_W   = $clog2(CAPACITY + 1);
    localparam int CMP_W = ((M_W > SIZE_W) ? M_W : SIZE_W) + 1;

    logic [SIZE_W-1:0] table_size_reg;
    logic [M_W-1:0]    m;

    cmd_t              push_cmd;
    cmd_t              head;
    logic              push;
    logic              pop;
    logic              queue_full;
    logic              head_valid;
    logic              clear_busy;

    // table size register keeps the raw value written
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_size_reg <= TABLE_SIZE_RESET;
        end
        else if (cfg_wr_en)
        begin
            table_size_reg <= cfg_wr_data;
        end
    end

    // active size: zero acts as one, above capacity acts as capacity
    always_comb
    begin
        priority if (table_size_reg == '0)
        begin
            m = M_W'(1);
        end
        else if (CMP_W'(table_size_reg) > CMP_W'(CAPACITY))
        begin
            m = M_W'(CAPACITY);
        end
        else
        begin
            m = M_W'(table_size_reg);
        end
    end

    // front: range checks and step reduction, one beat pushed per accept
    dht_front #(
        .M_W (M_W)
    ) u_front (
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .req_type    (req_type),
        .key         (key),
        .probe_start (probe_start),
        .probe_step  (probe_step),
        .m           (m),
        .queue_full  (queue_full),
        .clear_busy  (clear_busy),
        .push        (push),
        .cmd         (push_cmd)
    );

    // decouples request acceptance from the probe engine
    dht_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .pop        (pop),
        .full       (queue_full),
        .head_valid (head_valid),
        .head       (head)
    );

    // back: slot stores and probe sequencer, result register toward rsp channel
    dht_back #(
        .CAPACITY (CAPACITY),
        .M_W      (M_W)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .m           (m),
        .head_valid  (head_valid),
        .head        (head),
        .pop         (pop),
        .clear_busy  (clear_busy),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .success     (success),
        .slot        (slot),
        .bad_request (bad_request)
    );

endmodule

FILE: design/dht_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module dht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: design/dht_front.sv
// request front: range checks, step reduction and queue push
// depends on dht_pkg
module dht_front #(
    parameter int M_W = 11
) (
    input  logic                          req_valid,
    output logic                          req_stall,
    input  logic [dht_pkg::OP_W-1:0]      req_type,
    input  logic [dht_pkg::KEY_W-1:0]     key,
    input  logic [dht_pkg::START_W-1:0]   probe_start,
    input  logic [dht_pkg::STEP_W-1:0]    probe_step,
    input  logic [M_W-1:0]                m,
    input  logic                          queue_full,
    input  logic                          clear_busy,
    output logic                          push,
    output dht_pkg::cmd_t                 cmd
);
    import dht_pkg::*;

    localparam int CMP_W = ((M_W > STEP_W) ? M_W : STEP_W) + 1;

    logic [CMP_W-1:0] m_w;
    logic [CMP_W-1:0] start_w;
    logic [CMP_W-1:0] step_w;
    logic [CMP_W-1:0] inc_w;

    assign req_stall = queue_full || clear_busy;
    assign push      = req_valid && !req_stall;

    always_comb
    begin
        m_w     = CMP_W'(m);
        start_w = CMP_W'(probe_start);
        step_w  = CMP_W'(probe_step);

        // step is at most m+1, so one subtract gives step mod m
        priority if (m_w == CMP_W'(1))
        begin
            inc_w = '0;
        end
        else if (step_w >= m_w)
        begin
            inc_w = step_w - m_w;
        end
        else
        begin
            inc_w = step_w;
        end

        cmd.op    = req_type;
        cmd.key   = key;
        cmd.start = probe_start;
        cmd.inc   = STEP_W'(inc_w);
        cmd.bad   = (start_w >= m_w) || (step_w > (m_w + CMP_W'(1)));
        cmd.nop   = (req_type == OP_UNUSED);
    end

endmodule

FILE: design/dht_queue.sv
// short command queue between front and back
// depends on dht_pkg
module dht_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  dht_pkg::cmd_t push_cmd,
    input  logic          pop,
    output logic          full,
    output logic          head_valid,
    output dht_pkg::cmd_t head
);
    import dht_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t             entries_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full       = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        unique case ({push, pop})
            2'b10:   count_next = count_reg + CNT_W'(1);
            2'b01:   count_next = count_reg - CNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

FILE: design/dht_back.sv
// probe engine: slot stores, clearing sweep, probe sequencer, result register
// depends on dht_pkg and dht_ram
module dht_back #(
    parameter int CAPACITY = 1024,
    parameter int M_W      = 11
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [M_W-1:0]               m,
    input  logic                         head_valid,
    input  dht_pkg::cmd_t                head,
    output logic                         pop,
    output logic                         clear_busy,
    output logic                         rsp_valid,
    input  logic                         rsp_stall,
    output logic                         success,
    output logic [dht_pkg::SLOT_W-1:0]   slot,
    output logic                         bad_request
);
    import dht_pkg::*;

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int SUM_W = IDX_W + 1;

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_PROBE = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [IDX_W-1:0]  pos_reg, pos_next;
    logic [IDX_W-1:0]  inc_reg, inc_next;
    logic [IDX_W-1:0]  cnt_reg, cnt_next;
    logic [OP_W-1:0]   op_reg, op_next;
    logic [KEY_W-1:0]  key_reg, key_next;
    logic              rsp_valid_reg, rsp_valid_next;
    logic              success_reg, success_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic              bad_reg, bad_next;

    logic              tag_we;
    logic [TAG_W-1:0]  tag_wdata;
    logic [TAG_W-1:0]  tag_rdata;
    logic              key_we;
    logic [KEY_W-1:0]  key_rdata;
    logic [IDX_W-1:0]  raddr;

    logic [SUM_W-1:0]  sum;
    logic [SUM_W-1:0]  m_s;
    logic [IDX_W-1:0]  pos_step;
    logic [IDX_W-1:0]  m_last;
    logic              rsp_free;
    logic              lookup;
    logic              found;
    logic              stop_empty;

    dht_ram #(
        .WIDTH (TAG_W),
        .DEPTH (CAPACITY)
    ) u_tag_ram (
        .clk   (clk),
        .we    (tag_we),
        .waddr (pos_reg),
        .wdata (tag_wdata),
        .raddr (raddr),
        .rdata (tag_rdata)
    );

    dht_ram #(
        .WIDTH (KEY_W),
        .DEPTH (CAPACITY)
    ) u_key_ram (
        .clk   (clk),
        .we    (key_we),
        .waddr (pos_reg),
        .wdata (key_reg),
        .raddr (raddr),
        .rdata (key_rdata)
    );

    assign clear_busy  = (state_reg == ST_CLEAR);
    assign rsp_valid   = rsp_valid_reg;
    assign success     = success_reg;
    assign slot        = slot_reg;
    assign bad_request = bad_reg;

    always_comb
    begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        inc_next       = inc_reg;
        cnt_next       = cnt_reg;
        op_next        = op_reg;
        key_next       = key_reg;
        rsp_valid_next = rsp_valid_reg;
        success_next   = success_reg;
        slot_next      = slot_reg;
        bad_next       = bad_reg;
        pop            = 1'b0;
        tag_we         = 1'b0;
        tag_wdata      = TAG_EMPTY;
        key_we         = 1'b0;
        raddr          = pos_reg;

        rsp_free = !rsp_valid_reg || !rsp_stall;
        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        // next probe position, wrapped into the active size
        m_s      = SUM_W'(m);
        sum      = SUM_W'(pos_reg) + SUM_W'(inc_reg);
        pos_step = (sum >= m_s) ? IDX_W'(sum - m_s) : IDX_W'(sum);
        m_last   = IDX_W'(m - M_W'(1));

        lookup     = (op_reg == OP_SEARCH) || (op_reg == OP_DELETE);
        stop_empty = lookup && (tag_rdata == TAG_EMPTY);
        if (lookup)
        begin
            found = (tag_rdata == TAG_USED) && (key_rdata == key_reg);
        end
        else
        begin
            found = (tag_rdata == TAG_EMPTY) || (tag_rdata == TAG_DELETED);
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                tag_we = 1'b1;
                if (pos_reg == IDX_W'(CAPACITY - 1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    pos_next = pos_reg + IDX_W'(1);
                end
            end
            ST_IDLE:
            begin
                raddr = IDX_W'(head.start);
                if (head_valid && rsp_free)
                begin
                    pop = 1'b1;
                    if (head.bad || head.nop)
                    begin
                        rsp_valid_next = 1'b1;
                        success_next   = 1'b0;
                        slot_next      = '0;
                        bad_next       = head.bad;
                    end
                    else
                    begin
                        pos_next   = IDX_W'(head.start);
                        inc_next   = IDX_W'(head.inc);
                        cnt_next   = '0;
                        op_next    = head.op;
                        key_next   = head.key;
                        state_next = ST_PROBE;
                    end
                end
            end
            ST_PROBE:
            begin
                // read ahead at the next position, used only if probing goes on
                raddr = pos_step;
                priority if (found)
                begin
                    if (op_reg == OP_INSERT)
                    begin
                        tag_we    = 1'b1;
                        tag_wdata = TAG_USED;
                        key_we    = 1'b1;
                    end
                    else if (op_reg == OP_DELETE)
                    begin
                        tag_we    = 1'b1;
                        tag_wdata = TAG_DELETED;
                    end
                    rsp_valid_next = 1'b1;
                    success_next   = 1'b1;
                    slot_next      = SLOT_W'(pos_reg);
                    bad_next       = 1'b0;
                    state_next     = ST_IDLE;
                end
                else if (stop_empty || (cnt_reg == m_last))
                begin
                    rsp_valid_next = 1'b1;
                    success_next   = 1'b0;
                    slot_next      = '0;
                    bad_next       = 1'b0;
                    state_next     = ST_IDLE;
                end
                else
                begin
                    pos_next = pos_step;
                    cnt_next = cnt_reg + IDX_W'(1);
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
                pos_next   = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            pos_reg       <= '0;
            cnt_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            cnt_reg       <= cnt_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        inc_reg     <= inc_next;
        op_reg      <= op_next;
        key_reg     <= key_next;
        success_reg <= success_next;
        slot_reg    <= slot_next;
        bad_reg     <= bad_next;
    end

endmodule

FILE: design/dht_checker.sv
// port-level checks on the double hash table, bound to the top level
// depends on dht_pkg and double_hash_table_defines.svh
`include "double_hash_table_defines.svh"

module dht_port_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          req_stall,
    input logic                          rsp_valid,
    input logic                          rsp_stall,
    input logic                          success,
    input logic [dht_pkg::SLOT_W-1:0]    slot,
    input logic                          bad_request
);

    logic                          rsp_wait;
    logic [dht_pkg::SLOT_W+1:0]    rsp_beat;

    assign rsp_wait = rsp_valid && rsp_stall;
    assign rsp_beat = {success, slot, bad_request};

    // a stalled result beat holds
    `DHT_ASSERT_NEXT(a_rsp_hold, rsp_wait, rsp_valid && $stable(rsp_beat), "stalled beat changed")

    // a rejected request never reports success
    `DHT_ASSERT_IMPLY(a_bad_no_success, rsp_valid && bad_request, !success, "bad with success")

    // a failed beat carries slot zero
    `DHT_ASSERT_IMPLY(a_fail_slot_zero, rsp_valid && !success, slot == '0, "failed beat slot")

    // the clearing sweep holds off requests right after reset
    `DHT_ASSERT_IMPLY(a_reset_stall, $rose(rst_n), req_stall && !rsp_valid, "open during clear")

endmodule

bind double_hash_table dht_port_checker u_dht_checker (.*);

FILE: verif/dht_checker.sv
// dht_checker: watches the request and result channels of the double hash table,
// keeps its own copy of the slot store and table size, and compares every result beat
// depends on dht_pkg for field widths, operation codes and slot tags
`timescale 1ns / 100ps

module dht_checker #(
    parameter int CAPACITY = 1024
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [dht_pkg::SIZE_W-1:0]    cfg_wr_data,
    input  logic                          req_valid,
    input  logic                          req_stall,
    input  logic [dht_pkg::OP_W-1:0]      req_type,
    input  logic [dht_pkg::KEY_W-1:0]     key,
    input  logic [dht_pkg::START_W-1:0]   probe_start,
    input  logic [dht_pkg::STEP_W-1:0]    probe_step,
    input  logic                          rsp_valid,
    input  logic                          rsp_stall,
    input  logic                          success,
    input  logic [dht_pkg::SLOT_W-1:0]    slot,
    input  logic                          bad_request,
    output int                            fail_count,
    output int                            outstanding
);
    import dht_pkg::*;

    typedef struct packed {
        logic              ok;
        logic [SLOT_W-1:0] slot;
        logic              bad;
    } outcome_t;

    logic [TAG_W-1:0]  tag_mem [CAPACITY];
    logic [KEY_W-1:0]  key_mem [CAPACITY];
    logic [SIZE_W-1:0] size_reg;
    outcome_t          probe_outcomes [$];

    // register value as the probe logic sees it
    function automatic int live_size();
        if (size_reg == '0)
            return 1;
        if (int'(size_reg) > CAPACITY)
            return CAPACITY;
        return int'(size_reg);
    endfunction

    // walks the probe sequence and updates the slot store like the block does
    function automatic outcome_t probe_table(input logic [OP_W-1:0] op,
                                             input logic [KEY_W-1:0] k,
                                             input logic [START_W-1:0] start,
                                             input logic [STEP_W-1:0] step);
        outcome_t res;
        int m;
        int pos;
        int inc;
        int i;
        res = '0;
        m = live_size();
        if (int'(start) >= m || int'(step) > m + 1)
        begin
            res.bad = 1'b1;
            return res;
        end
        if (op == OP_UNUSED)
            return res;
        inc = int'(step) % m;
        pos = int'(start);
        for (i = 0; i < m; i++)
        begin
            if (op == OP_INSERT)
            begin
                if (tag_mem[pos] == TAG_EMPTY || tag_mem[pos] == TAG_DELETED)
                begin
                    tag_mem[pos] = TAG_USED;
                    key_mem[pos] = k;
                    res.ok = 1'b1;
                    res.slot = pos[SLOT_W-1:0];
                    break;
                end
            end
            else
            begin
                if (tag_mem[pos] == TAG_USED && key_mem[pos] == k)
                begin
                    if (op == OP_DELETE)
                        tag_mem[pos] = TAG_DELETED;
                    res.ok = 1'b1;
                    res.slot = pos[SLOT_W-1:0];
                    break;
                end
                if (tag_mem[pos] == TAG_EMPTY)
                    break;
            end
            pos = pos + inc;
            if (pos >= m)
                pos = pos - m;
        end
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        outcome_t want;
        if (!rst_n)
        begin
            size_reg = TABLE_SIZE_RESET;
            for (int j = 0; j < CAPACITY; j++)
                tag_mem[j] = TAG_EMPTY;
            probe_outcomes.delete();
            fail_count = 0;
            outstanding = 0;
        end
        else
        begin
            // result beat belongs to an earlier request, so pop before push
            if (rsp_valid && !rsp_stall)
            begin
                if (probe_outcomes.size() == 0)
                begin
                    $error("unexpected result beat: success %0d slot %0d bad_request %0d",
                           success, slot, bad_request);
                    fail_count++;
                end
                else
                begin
                    want = probe_outcomes.pop_front();
                    if (success !== want.ok)
                    begin
                        $error("success expected %0d got %0d", want.ok, success);
                        fail_count++;
                    end
                    if (slot !== want.slot)
                    begin
                        $error("slot expected %0d got %0d", want.slot, slot);
                        fail_count++;
                    end
                    if (bad_request !== want.bad)
                    begin
                        $error("bad_request expected %0d got %0d", want.bad, bad_request);
                        fail_count++;
                    end
                end
            end
            if (req_valid && !req_stall)
                probe_outcomes.push_back(probe_table(req_type, key, probe_start, probe_step));
            if (cfg_wr_en)
                size_reg = cfg_wr_data;
            outstanding = probe_outcomes.size();
        end
    end

endmodule

FILE: verif/tb_top.sv
// tb_top: stimulus and verdict for the double hash table
// instantiates the block and dht_checker side by side; depends on dht_pkg
`timescale 1ns / 100ps

module tb_top;
    import dht_pkg::*;

    localparam int CAPACITY = 1024;
    localparam int KEY_POOL = 8;
    localparam int ITEM_GOAL = 950;
    localparam logic [KEY_W-1:0] KEY_MAX = '1;

    logic               clk;
    logic               rst_n = 1'b0;
    logic               cfg_wr_en = 1'b0;
    logic [SIZE_W-1:0]  cfg_wr_data = '0;
    logic               req_valid = 1'b0;
    logic               req_stall;
    logic [OP_W-1:0]    req_type = OP_INSERT;
    logic [KEY_W-1:0]   key = '0;
    logic [START_W-1:0] probe_start = '0;
    logic [STEP_W-1:0]  probe_step = '0;
    logic               rsp_valid;
    logic               rsp_stall = 1'b0;
    logic               success;
    logic [SLOT_W-1:0]  slot;
    logic               bad_request;

    int                 fail_count;
    int                 outstanding;
    int                 items_sent = 0;

    // when set, neither side inserts gaps or stalls
    bit                 steady = 1'b0;

    // keys reused within a phase so that searches and deletes actually hit
    logic [KEY_W-1:0]   key_pool [KEY_POOL];

    double_hash_table #(
        .CAPACITY (CAPACITY)
    ) u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .req_type    (req_type),
        .key         (key),
        .probe_start (probe_start),
        .probe_step  (probe_step),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .success     (success),
        .slot        (slot),
        .bad_request (bad_request)
    );

    dht_checker #(
        .CAPACITY (CAPACITY)
    ) u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .req_type    (req_type),
        .key         (key),
        .probe_start (probe_start),
        .probe_step  (probe_step),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .success     (success),
        .slot        (slot),
        .bad_request (bad_request),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // one request beat: optional gap with valid low, then hold until accepted
    // entered and left at a falling edge, valid stays high across back-to-back beats
    task automatic drive_request(input logic [OP_W-1:0] op,
                                 input logic [KEY_W-1:0] k,
                                 input logic [START_W-1:0] start,
                                 input logic [STEP_W-1:0] step);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 13);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_valid   <= 1'b1;
        req_type    <= op;
        key         <= k;
        probe_start <= start;
        probe_step  <= step;
        do @(posedge clk); while (req_stall);
        items_sent++;
        @(negedge clk);
    endtask

    // sender goes quiet until every outstanding result beat has been taken
    task automatic drain_results();
        req_valid <= 1'b0;
        do @(negedge clk); while (outstanding != 0);
    endtask

    // table size may only change with nothing in flight
    task automatic write_table_size(input logic [SIZE_W-1:0] value);
        drain_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // random request for an effective size of m slots
    // mostly well-formed probes over the key pool, a few bad probes and unknown ops
    task automatic send_random(input int m);
        int pick;
        int start_v;
        int step_v;
        logic [31:0] raw;
        logic [OP_W-1:0] op;
        logic [KEY_W-1:0] k;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            op = OP_INSERT;
        else if (pick < 70)
            op = OP_SEARCH;
        else if (pick < 97)
            op = OP_DELETE;
        else
            op = OP_UNUSED;
        raw = $urandom;
        if ($urandom_range(0, 9) == 0)
            k = raw[KEY_W-1:0];
        else
            k = key_pool[$urandom_range(0, KEY_POOL - 1)];
        start_v = $urandom_range(0, m - 1);
        step_v = $urandom_range(0, m + 1);
        pick = $urandom_range(0, 99);
        if (pick < 3 && m < CAPACITY)
            start_v = $urandom_range(m, CAPACITY - 1);
        else if (pick < 6)
            step_v = $urandom_range(m + 2, 2047);
        drive_request(op, k, start_v[START_W-1:0], step_v[STEP_W-1:0]);
    endtask

    // result side: random stall before each beat, then take it
    initial
    begin : result_sink
        int hold;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            hold = steady ? 0 : $urandom_range(0, 13);
            if (hold > 0)
            begin
                rsp_stall <= 1'b1;
                repeat (hold) @(negedge clk);
            end
            rsp_stall <= 1'b0;
            do @(posedge clk); while (!rsp_valid);
            @(negedge clk);
        end
    end

    initial
    begin : stimulus
        int phase;
        int pick;
        int size_val;
        int m;
        int n_items;
        int drain_at;
        logic [31:0] raw;

        // reset asserted first, then released at a falling edge
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        // the block sweeps its tags after reset and holds off requests meanwhile
        do @(negedge clk); while (req_stall);

        // directed part, reset size of 1024 slots
        drive_request(OP_INSERT, '0, 10'd0, 11'd0);
        drive_request(OP_INSERT, KEY_MAX, 10'd1023, 11'd1025);
        drive_request(OP_SEARCH, KEY_MAX, 10'd1023, 11'd1025);
        // duplicate key gets a second slot
        drive_request(OP_INSERT, KEY_MAX, 10'd1023, 11'd1);
        drive_request(OP_SEARCH, '0, 10'd0, 11'd0);
        drive_request(OP_DELETE, '0, 10'd0, 11'd0);
        // zero step over a tombstone: the whole probe budget on one slot
        drive_request(OP_SEARCH, '0, 10'd0, 11'd0);
        // insert reuses the tombstone
        drive_request(OP_INSERT, 31'd5, 10'd0, 11'd0);
        drive_request(OP_UNUSED, 31'd5, 10'd0, 11'd0);
        drive_request(OP_SEARCH, 31'd5, 10'd0, 11'd1026);
        drive_request(OP_INSERT, KEY_MAX, 10'd1023, 11'd2047);
        drive_request(OP_DELETE, 31'd12345, 10'd512, 11'd3);

        // single slot table, already holding a key: full on insert
        write_table_size(11'd1);
        drive_request(OP_INSERT, 31'd1, 10'd0, 11'd2);
        drive_request(OP_INSERT, 31'd1, 10'd1, 11'd0);
        drive_request(OP_INSERT, 31'd1, 10'd0, 11'd3);
        drive_request(OP_DELETE, 31'd5, 10'd0, 11'd2);
        drive_request(OP_INSERT, 31'd9, 10'd0, 11'd0);

        // size zero behaves as one slot
        write_table_size(11'd0);
        drive_request(OP_SEARCH, 31'd9, 10'd0, 11'd2);
        drive_request(OP_SEARCH, 31'd9, 10'd1, 11'd0);

        // size above the capacity behaves as the full capacity
        write_table_size(11'd2047);
        drive_request(OP_SEARCH, KEY_MAX, 10'd1023, 11'd1025);
        // step of the table size never leaves an occupied slot: full
        drive_request(OP_INSERT, 31'd3, 10'd1023, 11'd1024);

        // random phases, each with its own size, key pool and idling style
        phase = 0;
        while (items_sent < ITEM_GOAL)
        begin
            pick = $urandom_range(0, 19);
            if (phase == 0)
                size_val = 1024;
            else if (pick == 0)
                size_val = 0;
            else if (pick == 1)
                size_val = $urandom_range(1025, 2047);
            else if (pick < 12)
                size_val = $urandom_range(1, 16);
            else if (pick < 17)
                size_val = $urandom_range(17, 128);
            else
                size_val = $urandom_range(129, 1024);
            m = (size_val == 0) ? 1 : ((size_val > CAPACITY) ? CAPACITY : size_val);
            write_table_size(size_val[SIZE_W-1:0]);

            for (int j = 0; j < KEY_POOL; j++)
            begin
                raw = $urandom;
                key_pool[j] = ($urandom_range(0, 3) == 0) ? KEY_W'(j) : raw[KEY_W-1:0];
            end
            steady = ($urandom_range(0, 3) == 0);
            n_items = $urandom_range(30, 80);
            // sender waits for a full drain somewhere in the first and in some others
            drain_at = (phase == 0 || $urandom_range(0, 2) == 0) ?
                       $urandom_range(0, n_items - 1) : -1;

            for (int j = 0; j < n_items && items_sent < ITEM_GOAL; j++)
            begin
                if (j == drain_at)
                    drain_results();
                send_random(m);
            end
            phase++;
        end

        steady = 1'b0;
        drain_results();
        repeat (20) @(negedge clk);
        if (fail_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // hard stop well beyond the slowest legal run
    initial
    begin : watchdog
        #(50_000_000);
        $display("DONE: errors detected");
        $finish;
    end

endmodule
